/* rtl/tlv8_record_parser_defines.svh */
// ----------------------------------------------------------------------------
// TLV8 record parser assertion macros
// Shared property shapes for the parser's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TLV8_RECORD_PARSER_DEFINES_SVH
`define TLV8_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TLV8_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlv8 check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define TLV8_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlv8 check failed: next-cycle implication");

`endif

/* rtl/tlv8_pkg.sv */
// ----------------------------------------------------------------------------
// TLV8 parser package
// Payload structs, byte roles, parse phases and queue types.
// ----------------------------------------------------------------------------
package tlv8_pkg;

   localparam int SLOT_W    = 4;
   localparam int OFFSET_W  = 16;
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = 1;
   localparam int Q_COUNT_W = 2;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

   typedef enum logic [1:0] {
      ROLE_TYPE   = 2'd0,
      ROLE_LENGTH = 2'd1,
      ROLE_VALUE  = 2'd2
   } role_type;

   typedef enum logic [1:0] {
      PH_TYPE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_VALUE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [1:0]          byte_role;
      logic [SLOT_W-1:0]   slot;
      logic [7:0]          record_type;
      logic [7:0]          value_byte;
      logic [OFFSET_W-1:0] record_offset;
      logic                new_record;
      logic                table_full;
      logic                truncated;
      logic                message_done;
   } rsp_type;

   // One classified byte waiting for the record table.
   typedef struct packed {
      role_type   role;
      logic [7:0] data;
      logic       last;
      logic       trunc;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

/* rtl/tlv8_record_parser.sv */
// ----------------------------------------------------------------------------
// TLV8 record parser
// Byte-serial type/length/value parser with a merging record table.
// ----------------------------------------------------------------------------
// One byte per cycle sustained while neither side stalls.
// The front end frames each byte (type, length or value) from its phase and
// fragment count and pushes it into a two-entry queue; the back end matches
// type bytes against up to MAX_RECORDS table slots in one parallel compare,
// tracks each merged record's length (saturating at 65535) and registers the
// result. The record table lives in flip-flops with a valid bit per slot and
// clears on the byte that carries message_end. A new type that finds the
// table full raises table_full on every byte of its triple, and those bytes
// report slot 0 and offset 0. truncated marks a message_end that falls inside
// a triple. Either side may stall independently; the queue absorbs the gap.
// ----------------------------------------------------------------------------
`include "tlv8_record_parser_defines.svh"

module tlv8_record_parser import tlv8_pkg::*; #(
   parameter int MAX_RECORDS = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic         push;
   logic         pop;
   q_entry_type  push_entry;
   q_entry_type  head;
   q_status_type q_status;

   // hold the request side while the queue has no room
   assign req_stall = q_status.full;

   // framing: role, truncation and message end per transfer
   tlv8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouple framing from table lookup
   tlv8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // record table, offsets and the result register
   tlv8_back #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a dropped triple never reports a slot or an offset
   `TLV8_ASSERT_IMPLY(a_full_no_slot, clock, reset,
      rsp_valid && rsp_data.table_full,
      (rsp_data.slot == '0) && (rsp_data.record_offset == '0))

   // a fresh slot is claimed only by a type byte that was not dropped
   `TLV8_ASSERT_IMPLY(a_new_on_type, clock, reset,
      rsp_valid && rsp_data.new_record,
      (rsp_data.byte_role == 2'(ROLE_TYPE)) && !rsp_data.table_full)

   // only value bytes carry an offset
   `TLV8_ASSERT_IMPLY(a_offset_value, clock, reset,
      rsp_valid && (rsp_data.record_offset != '0),
      rsp_data.byte_role == 2'(ROLE_VALUE))

   // a pushed byte leaves the queue non-empty next cycle
   `TLV8_ASSERT_NEXT(a_push_lands, clock, reset, push && !pop, q_status.not_empty)

endmodule

/* rtl/tlv8_front.sv */
// ----------------------------------------------------------------------------
// TLV8 framing front end
// Tracks the type/length/value phase and tags each byte with its role.
// ----------------------------------------------------------------------------
module tlv8_front import tlv8_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_type      req_data,
   input  q_status_type q_status,
   output logic         push,
   output q_entry_type  push_entry
);

   phase_type  phase_ff, phase_in;
   logic [7:0] remain_ff, remain_in;

   assign push = req_valid && !q_status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         remain_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
      end
   end

   always_comb begin
      phase_type nxt;
      nxt                   = phase_ff;
      phase_in              = phase_ff;
      remain_in             = remain_ff;
      push_entry.role       = ROLE_TYPE;
      push_entry.data       = req_data.data_byte;
      push_entry.last       = req_data.message_end;
      push_entry.trunc      = 1'b0;
      case (phase_ff)
         PH_LEN: begin
            push_entry.role = ROLE_LENGTH;
            nxt             = (req_data.data_byte == 8'd0) ? PH_TYPE : PH_VALUE;
         end
         PH_VALUE: begin
            push_entry.role = ROLE_VALUE;
            nxt             = (remain_ff == 8'd1) ? PH_TYPE : PH_VALUE;
         end
         default: begin
            push_entry.role = ROLE_TYPE;
            nxt             = PH_LEN;
         end
      endcase
      push_entry.trunc = req_data.message_end && (nxt != PH_TYPE);
      if (push) begin
         case (phase_ff)
            PH_LEN:   remain_in = req_data.data_byte;
            PH_VALUE: remain_in = remain_ff - 8'd1;
            default:  remain_in = remain_ff;
         endcase
         phase_in = nxt;
         // end of message: restart framing
         if (req_data.message_end) begin
            phase_in  = PH_TYPE;
            remain_in = '0;
         end
      end
   end

endmodule

/* rtl/tlv8_queue.sv */
// ----------------------------------------------------------------------------
// TLV8 classified-byte queue
// Short FIFO that decouples framing from the record table.
// ----------------------------------------------------------------------------
module tlv8_queue import tlv8_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  q_entry_type  push_entry,
   input  logic         pop,
   output q_entry_type  head,
   output q_status_type status
);

   q_entry_type          mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_COUNT_W-1:0] count_ff, count_in;

   assign head             = mem_ff[rd_ptr_ff];
   assign status.full      = (count_ff == Q_COUNT_W'(Q_DEPTH));
   assign status.not_empty = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_COUNT_W'(push) - Q_COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/tlv8_back.sv */
// ----------------------------------------------------------------------------
// TLV8 record table back end
// Matches types to slots, tracks merged record lengths, drives results.
// ----------------------------------------------------------------------------
module tlv8_back import tlv8_pkg::*; #(
   parameter int MAX_RECORDS = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  q_entry_type  head,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam logic [SLOT_W-1:0] MAX_SLOTS = SLOT_W'(MAX_RECORDS);

   logic [MAX_RECORDS-1:0] valid_ff, valid_in;
   logic [7:0]             type_ff [MAX_RECORDS];
   logic [OFFSET_W-1:0]    len_ff  [MAX_RECORDS];
   logic [SLOT_W-1:0]      used_ff, used_in;
   logic [SLOT_W-1:0]      cur_slot_ff, cur_slot_in;
   logic [7:0]             cur_type_ff, cur_type_in;
   logic                   drop_ff, drop_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   hit;
   logic [SLOT_W-1:0]      hit_idx;
   logic                   type_we;
   logic                   len_we;
   logic [IDX_W-1:0]       len_idx;
   logic [OFFSET_W-1:0]    len_wdata;
   logic [OFFSET_W-1:0]    cur_len;

   assign pop       = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cur_len   = len_ff[cur_slot_ff[IDX_W-1:0]];

   // parallel tag match, lowest slot wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = MAX_RECORDS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (type_ff[i] == head.data)) begin
            hit     = 1'b1;
            hit_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      used_in      = used_ff;
      cur_slot_in  = cur_slot_ff;
      cur_type_in  = cur_type_ff;
      drop_in      = drop_ff;
      type_we      = 1'b0;
      len_we       = 1'b0;
      len_idx      = cur_slot_ff[IDX_W-1:0];
      len_wdata    = cur_len + 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (pop) begin
         rsp_valid_in         = 1'b1;
         rsp_in.byte_role     = 2'(head.role);
         rsp_in.value_byte    = head.data;
         rsp_in.record_offset = '0;
         rsp_in.new_record    = 1'b0;
         rsp_in.truncated     = head.trunc;
         rsp_in.message_done  = head.last;
         case (head.role)
            ROLE_TYPE: begin
               cur_type_in = head.data;
               drop_in     = 1'b0;
               if (hit) begin
                  cur_slot_in = hit_idx;
               end else if (used_ff < MAX_SLOTS) begin
                  cur_slot_in          = used_ff;
                  valid_in[used_ff[IDX_W-1:0]] = 1'b1;
                  type_we              = 1'b1;
                  len_we               = 1'b1;
                  len_idx              = used_ff[IDX_W-1:0];
                  len_wdata            = '0;
                  used_in              = used_ff + 1'b1;
                  rsp_in.new_record    = 1'b1;
               end else begin
                  cur_slot_in = '0;
                  drop_in     = 1'b1;
               end
            end
            ROLE_VALUE: begin
               if (!drop_ff) begin
                  rsp_in.record_offset = cur_len;
                  // saturate at the top of the length range
                  len_we = (cur_len != OFFSET_MAX);
               end
            end
            default: begin
            end
         endcase
         rsp_in.slot        = drop_in ? '0 : cur_slot_in;
         rsp_in.table_full  = drop_in;
         rsp_in.record_type = cur_type_in;
         if (head.last) begin
            valid_in    = '0;
            used_in     = '0;
            cur_slot_in = '0;
            cur_type_in = '0;
            drop_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         used_ff      <= '0;
         cur_slot_ff  <= '0;
         cur_type_ff  <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         cur_slot_ff  <= cur_slot_in;
         cur_type_ff  <= cur_type_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (type_we) begin
         type_ff[used_ff[IDX_W-1:0]] <= head.data;
      end
      if (len_we) begin
         len_ff[len_idx] <= len_wdata;
      end
   end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// TLV8 record parser testbench
// Streams type/length/value messages into the parser under random idling on
// both channels and checks every byte report against an in-bench model of
// the merging record table.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tlv8_pkg::*;

   localparam int TABLE_DEPTH  = 10;
   localparam int HOLD_CYCLES  = 80;
   localparam int STALL_LIMIT  = 5000;
   localparam int SETTLE       = 8;

   // -------------------------------------------------------------------------
   // Record table tracker: mirrors the parser's framing and slot table, keeps
   // the byte reports still owed by the block and matches them in order.
   // -------------------------------------------------------------------------
   class tlv8_tracker;
      phase_type   phase;
      logic [7:0]  cur_type;
      logic [3:0]  cur_slot;
      logic [7:0]  remaining;
      logic [7:0]  slot_tag [TABLE_DEPTH];
      bit          slot_live [TABLE_DEPTH];
      logic [15:0] rec_len [TABLE_DEPTH];
      int unsigned used;
      bit          dropping;
      rsp_type     report_q [$];
      int unsigned errors;

      function new();
         errors = 0;
         clear_table();
      endfunction

      function void clear_table();
         phase     = PH_TYPE;
         cur_type  = '0;
         cur_slot  = '0;
         remaining = '0;
         used      = 0;
         dropping  = 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_tag[i]  = '0;
            slot_live[i] = 1'b0;
            rec_len[i]   = '0;
         end
      endfunction

      // Work out the report for one transferred byte and queue it.
      function void take_byte(req_type r);
         rsp_type x;
         int      hit;
         x              = '0;
         x.value_byte   = r.data_byte;
         x.message_done = r.message_end;
         case (phase)
            PH_LEN: begin
               x.byte_role = ROLE_LENGTH;
               remaining   = r.data_byte;
               phase       = (r.data_byte == 8'd0) ? PH_TYPE : PH_VALUE;
            end
            PH_VALUE: begin
               x.byte_role = ROLE_VALUE;
               if (!dropping) begin
                  x.record_offset = rec_len[cur_slot];
                  // saturate the merged length
                  if (rec_len[cur_slot] != OFFSET_MAX)
                     rec_len[cur_slot] = rec_len[cur_slot] + 16'd1;
               end
               remaining = remaining - 8'd1;
               if (remaining == 8'd0)
                  phase = PH_TYPE;
            end
            default: begin
               x.byte_role = ROLE_TYPE;
               cur_type    = r.data_byte;
               dropping    = 1'b0;
               hit         = -1;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (hit < 0 && i < used && slot_live[i] && slot_tag[i] == r.data_byte)
                     hit = i;
               end
               if (hit >= 0) begin
                  cur_slot = 4'(hit);
               end else if (used < TABLE_DEPTH) begin
                  cur_slot        = 4'(used);
                  slot_live[used] = 1'b1;
                  slot_tag[used]  = r.data_byte;
                  rec_len[used]   = '0;
                  used++;
                  x.new_record = 1'b1;
               end else begin
                  cur_slot = '0;
                  dropping = 1'b1;
               end
               phase = PH_LEN;
            end
         endcase
         x.record_type = cur_type;
         if (dropping)
            x.table_full = 1'b1;
         else
            x.slot = cur_slot;
         if (r.message_end) begin
            x.truncated = (phase != PH_TYPE);
            clear_table();
         end
         report_q.push_back(x);
      endfunction

      function void flag(string what, logic [15:0] want, logic [15:0] got);
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         errors++;
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want)
            flag(name, want, got);
      endfunction

      // Compare one transferred report with the oldest one owed.
      function void match_report(rsp_type got);
         rsp_type want;
         if (report_q.size() == 0) begin
            flag("unexpected report, value_byte", 16'hxxxx, 16'(got.value_byte));
            return;
         end
         want = report_q.pop_front();
         check_field("byte_role", 16'(want.byte_role), 16'(got.byte_role));
         check_field("slot", 16'(want.slot), 16'(got.slot));
         check_field("record_type", 16'(want.record_type), 16'(got.record_type));
         check_field("value_byte", 16'(want.value_byte), 16'(got.value_byte));
         check_field("record_offset", want.record_offset, got.record_offset);
         check_field("new_record", 16'(want.new_record), 16'(got.new_record));
         check_field("table_full", 16'(want.table_full), 16'(got.table_full));
         check_field("truncated", 16'(want.truncated), 16'(got.truncated));
         check_field("message_done", 16'(want.message_done), 16'(got.message_done));
      endfunction

      function int unsigned pending();
         return report_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block hookup. Every input starts at a known value.
   // -------------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   tlv8_record_parser #(.MAX_RECORDS(TABLE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   tlv8_tracker tracker = new();

   // Idle rates in percent, set per phase by the stimulus process.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned bytes_sent   = 0;

   // The stimulus bumps hold_token to ask for a long receiver hold-off; only
   // the receiver process counts the hold cycles.
   int unsigned hold_token = 0;

   // Message under construction.
   req_type msg_q [$];

   // -------------------------------------------------------------------------
   // Receiver: take reports at the edge, then pick the stall for the next
   // cycle (random, or forced high during a hold-off).
   // -------------------------------------------------------------------------
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         tracker.match_report(rsp_data);
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: count cycles without any transfer on either channel.
   // -------------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[tlv8_record_parser] ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------

   // Offer one byte, with random idle cycles ahead of it, and hold it until
   // the block takes it. Valid stays high afterwards so back-to-back bytes
   // never see a low/high pair in one step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, message_end: last};
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      tracker.take_byte('{data_byte: b, message_end: last});
      bytes_sent++;
   endtask

   // Drop valid and wait until every owed report has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
   endtask

   task automatic send_queued();
      foreach (msg_q[i])
         send_byte(msg_q[i].data_byte, msg_q[i].message_end);
      msg_q.delete();
   endtask

   function automatic void push_byte(logic [7:0] b);
      msg_q.push_back('{data_byte: b, message_end: 1'b0});
   endfunction

   function automatic void mark_end();
      msg_q[msg_q.size() - 1].message_end = 1'b1;
   endfunction

   function automatic void add_triple(logic [7:0] tag, int unsigned len);
      push_byte(tag);
      push_byte(8'(len));
      for (int unsigned i = 0; i < len; i++)
         push_byte(8'($urandom));
   endfunction

   // Mostly short fragments, some empty, a few long ones up to 255.
   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15)
         return 0;
      if (r < 88)
         return $urandom_range(1, 6);
      if (r < 98)
         return $urandom_range(7, 40);
      return ($urandom_range(1) != 0) ? 255 : $urandom_range(41, 254);
   endfunction

   // Build and send one random message: mostly well-formed, some cut short,
   // some plain noise.
   task automatic send_random_message();
      int unsigned kind;
      int unsigned n;
      int unsigned pool;
      int unsigned cut;
      bit          wide;
      logic [7:0]  base;
      kind = $urandom_range(99);
      base = 8'($urandom);
      if (kind < 85) begin
         // wide messages carry more distinct tags than the table holds
         wide = ($urandom_range(99) < 20);
         n    = wide ? $urandom_range(11, 16) : $urandom_range(1, 8);
         pool = $urandom_range(1, 6);
         for (int unsigned i = 0; i < n; i++) begin
            if (wide)
               add_triple(base + 8'(i), $urandom_range(0, 2));
            else
               add_triple(base + 8'($urandom_range(pool - 1)), pick_length());
         end
         if (kind >= 70) begin
            // cut the message at a random byte
            cut = $urandom_range(0, msg_q.size() - 1);
            msg_q = msg_q[0:cut];
         end
         mark_end();
      end else begin
         n = $urandom_range(1, 24);
         for (int unsigned i = 0; i < n; i++)
            msg_q.push_back('{data_byte: 8'($urandom),
                              message_end: ($urandom_range(99) < 8)});
         if ($urandom_range(1) != 0)
            mark_end();
      end
      send_queued();
   endtask

   task automatic run_random(input int unsigned upto);
      while (bytes_sent < upto)
         send_random_message();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase one: sender idles lightly, receiver heavily.
      req_idle_pct = 24;
      rsp_idle_pct = 71;

      // Empty record, extreme bytes, a merge into the first slot and an end
      // exactly on the last value byte.
      add_triple(8'h00, 0);
      push_byte(8'hFF); push_byte(8'h02); push_byte(8'h00); push_byte(8'hFF);
      push_byte(8'h00); push_byte(8'h01); push_byte(8'h5A);
      mark_end();
      send_queued();
      // End on a type byte.
      push_byte(8'h12);
      mark_end();
      send_queued();
      // End on a nonzero length byte.
      push_byte(8'h34); push_byte(8'h03);
      mark_end();
      send_queued();
      // End on a zero length byte: the triple is complete.
      push_byte(8'h34); push_byte(8'h00);
      mark_end();
      send_queued();
      // End inside the value bytes.
      push_byte(8'h56); push_byte(8'h04); push_byte(8'h01); push_byte(8'h02);
      mark_end();
      send_queued();

      // Hold the receiver off while the sender keeps pushing, so the queue
      // fills and the input stalls; then pause until everything is back.
      wait_drained();
      hold_token++;
      req_idle_pct = 0;
      add_triple(8'h77, 30);
      add_triple(8'h78, 8);
      mark_end();
      send_queued();
      req_idle_pct = 24;
      wait_drained();

      run_random(650);
      wait_drained();

      // Phase two: the other way round.
      req_idle_pct = 71;
      rsp_idle_pct = 24;
      run_random(1300);
      wait_drained();

      // Phase three: no idling on either side.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(1950);

      // Let the pipeline empty, then watch a few more cycles for strays.
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (tracker.errors == 0)
         $display("[tlv8_record_parser] OK");
      else
         $display("[tlv8_record_parser] ERROR");
      $finish;
   end

endmodule

/* tlv8_record_parser.f */
+incdir+rtl
rtl/tlv8_pkg.sv
rtl/tlv8_front.sv
rtl/tlv8_queue.sv
rtl/tlv8_back.sv
rtl/tlv8_record_parser.sv
tb/sv/tb.sv
